### hdl/dea_pkg.sv
// Shared types and constants for the daily energy accumulator.
// Used by dea_ring and daily_energy_accumulator_unit; depends on nothing else.

package dea_pkg;

    // Field widths fixed by the item format.
    localparam int SUM_W   = 56;
    localparam int POWER_W = 19;
    localparam int TIME_W  = 32;
    localparam int PROD_W  = POWER_W + TIME_W;
    localparam int SOC_W   = 14;
    localparam int LEVEL_W = 16;
    localparam int DATE_W  = 27;
    localparam int BUCKET_W = 40;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 9;
    localparam int MASK_W  = 5;
    localparam int SLOTS   = 6;

    // Largest clamped charge sample, in hundredths of percent.
    localparam int SOC_MAX = 10000;

    localparam int HISTORY_POINTS_DEF = 256;
    localparam logic [TIME_W-1:0] MAX_ELAPSED_RST = 32'd10000000;

    // Item kinds carried on the input tuser; the unused code acts as a read.
    typedef enum logic [1:0] {
        KIND_TICK      = 2'd0,
        KIND_RESET_DAY = 2'd1,
        KIND_READ      = 2'd2
    } kind_t;

    // Request from the front end to the history ring, one per accepted item.
    typedef struct packed {
        logic                       rd;
        logic                       cand;
        logic signed [LEVEL_W-1:0]  soc_level;
        logic [BUCKET_W-1:0]        bucket;
        logic [INDEX_W-1:0]         hidx;
    } ring_req_t;

endpackage

### hdl/dea_ring.sv
// State-of-charge history ring: one synchronous memory plus write pointer,
// fill count and last bucket. Depends on dea_pkg.

module dea_ring #(
    parameter int HISTORY_POINTS = dea_pkg::HISTORY_POINTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  dea_pkg::ring_req_t                 req,
    output logic [dea_pkg::COUNT_W-1:0]        hist_count,
    output logic [dea_pkg::SOC_W-1:0]          hist_value
);

    localparam int PW = $clog2(HISTORY_POINTS);
    localparam int CW = $clog2(HISTORY_POINTS + 1);
    localparam int AW = ((PW > dea_pkg::INDEX_W) ? PW : dea_pkg::INDEX_W) + 1;

    logic [dea_pkg::SOC_W-1:0]    ring_mem [HISTORY_POINTS];

    logic [PW-1:0]                wp_reg, wp_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic [dea_pkg::BUCKET_W-1:0] last_bucket_reg;
    logic                         lbv_reg;

    logic                         take;
    logic [dea_pkg::SOC_W-1:0]    level;
    logic [PW-1:0]                oldest;
    logic [AW-1:0]                pos;
    logic [PW-1:0]                rd_addr;
    logic                         hit;

    logic [dea_pkg::SOC_W-1:0]    rd_data_reg;
    logic [dea_pkg::SOC_W-1:0]    wdata_reg;
    logic                         byp_reg;
    logic                         valid_reg;
    logic [dea_pkg::COUNT_W-1:0]  count_reg;

    // Sample gating and clamp of the charge level.
    always_comb begin
        take = req.rd && req.cand && (!lbv_reg || (req.bucket != last_bucket_reg));
        if (req.soc_level < 0) begin
            level = '0;
        end else if (req.soc_level > dea_pkg::LEVEL_W'(dea_pkg::SOC_MAX)) begin
            level = dea_pkg::SOC_W'(dea_pkg::SOC_MAX);
        end else begin
            level = req.soc_level[dea_pkg::SOC_W-1:0];
        end
    end

    // Pointer and count after this item's sample.
    always_comb begin
        wp_next  = wp_reg;
        cnt_next = cnt_reg;
        if (take) begin
            wp_next = (wp_reg == PW'(HISTORY_POINTS - 1)) ? '0 : wp_reg + 1'b1;
            if (cnt_reg != CW'(HISTORY_POINTS)) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // Oldest-first read address; a valid index keeps the sum below twice the depth.
    always_comb begin
        oldest  = (cnt_next == CW'(HISTORY_POINTS)) ? wp_next : '0;
        pos     = AW'(oldest) + AW'(req.hidx);
        rd_addr = (pos >= AW'(HISTORY_POINTS)) ? PW'(pos - AW'(HISTORY_POINTS)) : PW'(pos);
        hit     = AW'(req.hidx) < AW'(cnt_next);
    end

    // Ring control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg          <= '0;
            cnt_reg         <= '0;
            last_bucket_reg <= '0;
            lbv_reg         <= 1'b0;
        end else if (take) begin
            wp_reg          <= wp_next;
            cnt_reg         <= cnt_next;
            last_bucket_reg <= req.bucket;
            lbv_reg         <= 1'b1;
        end
    end

    // Sample memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (take) begin
            ring_mem[wp_reg] <= level;
        end
        if (req.rd) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    // Per-item snapshot, with forwarding when the read hits the entry written now.
    always_ff @(posedge aclk) begin
        if (req.rd) begin
            wdata_reg <= level;
            byp_reg   <= take && (rd_addr == wp_reg);
            valid_reg <= hit;
            count_reg <= dea_pkg::COUNT_W'(cnt_next);
        end
    end

    assign hist_count = count_reg;
    assign hist_value = valid_reg ? (byp_reg ? wdata_reg : rd_data_reg) : '0;

endmodule

### hdl/daily_energy_accumulator_unit.sv
// Top level of the daily energy accumulator: decode, products, saturating sums.
// Depends on dea_pkg and dea_ring.
//
//   Channel  | Direction | Handshake             | Carries
//   s_       | in        | s_tvalid / s_tready   | one tick, reset-day or read item
//   m_       | out       | m_tvalid / m_tready   | six sums, ring count, one sample
//   cfg_     | in        | cfg_valid / cfg_ready | max_elapsed_us
//
// One item per clock cycle sustained while results are taken; each result passes the
// product register, then the sum and output register, before it is presented.
// Reset is synchronous; the sample memory is not cleared, its fill count hides
// entries never written, so no clearing pass is needed.
// With m_tready low the output holds, and the input stalls once the product
// stage is also full.

module daily_energy_accumulator_unit #(
    parameter int HISTORY_POINTS = dea_pkg::HISTORY_POINTS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_tvalid,
    output logic                      s_tready,
    // elapsed_us, inverter_online, pv_power_w, load_power_w, battery_power_w,
    // grid_power_w, finite_mask, soc_level, meter_date, sample_slot, history_index
    input  logic [207:0]              s_tdata,
    // kind
    input  logic [1:0]                s_tuser,

    output logic                      m_tvalid,
    input  logic                      m_tready,
    // pv_energy, load_energy, battery_charged, battery_discharged, grid_import,
    // grid_export, history_count, history_value
    output logic [359:0]              m_tdata,
    // day_cleared
    output logic                      m_tuser,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [31:0]               cfg_data
);

    localparam int SUM_W  = dea_pkg::SUM_W;
    localparam int PROD_W = dea_pkg::PROD_W;
    localparam int PW_W   = dea_pkg::POWER_W;

    typedef struct packed {
        logic                           clear;
        logic [dea_pkg::SLOTS-1:0]      add_en;
        logic [3:0][PROD_W-1:0]         prod;
    } stage_t;

    // Unpacked input fields.
    logic [dea_pkg::TIME_W-1:0]         elapsed_us;
    logic                               inverter_online;
    logic signed [PW_W-1:0]             pv_power_w, load_power_w;
    logic signed [PW_W-1:0]             battery_power_w, grid_power_w;
    logic [dea_pkg::MASK_W-1:0]         finite_mask;
    logic signed [dea_pkg::LEVEL_W-1:0] soc_level;
    logic [dea_pkg::DATE_W-1:0]         meter_date;
    logic [dea_pkg::BUCKET_W-1:0]       sample_slot;
    logic [dea_pkg::INDEX_W-1:0]        history_index;
    dea_pkg::kind_t                     kind;

    logic [dea_pkg::TIME_W-1:0]         max_elapsed_reg;
    logic [dea_pkg::DATE_W-1:0]         date_reg;
    logic [dea_pkg::SLOTS-1:0][SUM_W-1:0] sum_reg, sum_next;

    logic                               accept, advance, p1_move;
    logic                               is_tick, is_reset;
    logic                               new_day, integrate;
    logic                               bat_neg, grid_neg;
    logic [PW_W-1:0]                    bat_mag, grid_mag;
    stage_t                             p1_next, p1_reg;
    logic                               p1_valid_reg;

    logic                               out_valid_reg;
    logic                               out_cleared_reg;
    logic [dea_pkg::COUNT_W-1:0]        out_count_reg;
    logic [dea_pkg::SOC_W-1:0]          out_value_reg;

    dea_pkg::ring_req_t                 ring_req;
    logic [dea_pkg::COUNT_W-1:0]        ring_count;
    logic [dea_pkg::SOC_W-1:0]          ring_value;

    // Field extraction, lowest field first.
    always_comb begin
        elapsed_us      = s_tdata[31:0];
        inverter_online = s_tdata[32];
        pv_power_w      = s_tdata[51:33];
        load_power_w    = s_tdata[70:52];
        battery_power_w = s_tdata[89:71];
        grid_power_w    = s_tdata[108:90];
        finite_mask     = s_tdata[113:109];
        soc_level       = s_tdata[129:114];
        meter_date      = s_tdata[156:130];
        sample_slot     = s_tdata[196:157];
        history_index   = s_tdata[204:197];
        kind            = dea_pkg::kind_t'(s_tuser);
    end

    // Handshake: the output register frees the pipeline when empty or taken.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !p1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;
    assign p1_move  = p1_valid_reg && advance;
    assign cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_elapsed_reg <= dea_pkg::MAX_ELAPSED_RST;
        end else if (cfg_valid) begin
            max_elapsed_reg <= cfg_data;
        end
    end

    // Kind decode and day change.
    always_comb begin
        is_tick  = 1'b0;
        is_reset = 1'b0;
        case (kind)
            dea_pkg::KIND_TICK:      is_tick  = 1'b1;
            dea_pkg::KIND_RESET_DAY: is_reset = 1'b1;
            default:                 ;
        endcase
        new_day   = is_tick && (meter_date != '0) && (meter_date != date_reg);
        integrate = is_tick && inverter_online && (elapsed_us != '0)
                    && (elapsed_us <= max_elapsed_reg);
    end

    // Stored date follows reset-day commands and new valid dates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            date_reg <= '0;
        end else if (accept && (is_reset || new_day)) begin
            date_reg <= meter_date;
        end
    end

    // Products of power magnitude and elapsed time, with per-slot enables.
    always_comb begin
        bat_neg  = battery_power_w < 0;
        grid_neg = grid_power_w < 0;
        bat_mag  = bat_neg ? PW_W'(-battery_power_w) : PW_W'(battery_power_w);
        grid_mag = grid_neg ? PW_W'(-grid_power_w) : PW_W'(grid_power_w);

        p1_next.clear   = is_reset || new_day;
        p1_next.add_en[0] = integrate && finite_mask[0] && (pv_power_w > 0);
        p1_next.add_en[1] = integrate && finite_mask[1] && (load_power_w > 0);
        p1_next.add_en[2] = integrate && finite_mask[2] && bat_neg;
        p1_next.add_en[3] = integrate && finite_mask[2] && !bat_neg;
        p1_next.add_en[4] = integrate && finite_mask[3] && grid_neg;
        p1_next.add_en[5] = integrate && finite_mask[3] && !grid_neg;
        p1_next.prod[0] = PROD_W'(PW_W'(pv_power_w)) * PROD_W'(elapsed_us);
        p1_next.prod[1] = PROD_W'(PW_W'(load_power_w)) * PROD_W'(elapsed_us);
        p1_next.prod[2] = PROD_W'(bat_mag) * PROD_W'(elapsed_us);
        p1_next.prod[3] = PROD_W'(grid_mag) * PROD_W'(elapsed_us);
    end

    // Product stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            p1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_reg <= p1_next;
        end
    end

    // History ring request.
    always_comb begin
        ring_req.rd        = accept;
        ring_req.cand      = is_tick && (meter_date != '0) && inverter_online
                             && finite_mask[4];
        ring_req.soc_level = soc_level;
        ring_req.bucket    = sample_slot;
        ring_req.hidx      = history_index;
    end

    dea_ring #(
        .HISTORY_POINTS (HISTORY_POINTS)
    ) u_ring (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (ring_req),
        .hist_count (ring_count),
        .hist_value (ring_value)
    );

    // Saturating accumulation; slots 2/3 and 4/5 share the battery and grid products.
    always_comb begin
        logic [SUM_W:0]     total;
        logic [SUM_W-1:0]   base;
        logic [PROD_W-1:0]  addend;
        for (int i = 0; i < dea_pkg::SLOTS; i++) begin
            base   = p1_reg.clear ? '0 : sum_reg[i];
            addend = p1_reg.add_en[i] ? p1_reg.prod[(i < 2) ? i : (i >> 1) + 1] : '0;
            total  = {1'b0, base} + (SUM_W + 1)'(addend);
            sum_next[i] = total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
        end
    end

    // The sums double as the energy part of the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (p1_move) begin
            sum_reg <= sum_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_move) begin
            out_cleared_reg <= p1_reg.clear;
            out_count_reg   <= ring_count;
            out_value_reg   <= ring_value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_cleared_reg;
    assign m_tdata  = {1'b0, out_value_reg, out_count_reg,
                       sum_reg[5], sum_reg[4], sum_reg[3],
                       sum_reg[2], sum_reg[1], sum_reg[0]};

`ifndef ASSERT_OFF
    // An uncleared update never lowers the solar sum.
    a_sum_monotone: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_move && !p1_reg.clear |=> sum_reg[0] >= $past(sum_reg[0]))
        else $error("solar sum decreased without a clear");

    // Returned samples stay within the clamp range.
    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_value_reg <= dea_pkg::SOC_W'(dea_pkg::SOC_MAX))
        else $error("history sample above clamp limit");

    // Every transfer in occupies the product stage on the next cycle.
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> p1_valid_reg)
        else $error("accepted item lost before product stage");
`endif

endmodule

### test/tb_daily_energy_accumulator_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for daily_energy_accumulator_unit: a predictor of the daily sums
// and the charge history checks every result. Depends on dea_pkg and the unit's RTL.

module tb_daily_energy_accumulator_unit;

    localparam int SUM_W    = dea_pkg::SUM_W;
    localparam int POWER_W  = dea_pkg::POWER_W;
    localparam int TIME_W   = dea_pkg::TIME_W;
    localparam int SOC_W    = dea_pkg::SOC_W;
    localparam int LEVEL_W  = dea_pkg::LEVEL_W;
    localparam int DATE_W   = dea_pkg::DATE_W;
    localparam int BUCKET_W = dea_pkg::BUCKET_W;
    localparam int INDEX_W  = dea_pkg::INDEX_W;
    localparam int COUNT_W  = dea_pkg::COUNT_W;
    localparam int MASK_W   = dea_pkg::MASK_W;
    localparam int SLOTS    = dea_pkg::SLOTS;
    localparam int SOC_MAX  = dea_pkg::SOC_MAX;
    localparam logic [TIME_W-1:0] MAX_ELAPSED_RST = dea_pkg::MAX_ELAPSED_RST;

    localparam int HIST        = dea_pkg::HISTORY_POINTS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;

    localparam logic [1:0] KIND_SPARE = 2'd3;

    // Bit positions in finite_mask.
    localparam int MASK_PV   = 0;
    localparam int MASK_LOAD = 1;
    localparam int MASK_BAT  = 2;
    localparam int MASK_GRID = 3;
    localparam int MASK_SOC  = 4;

    // Order of the six sums in the result.
    localparam int SLOT_PV       = 0;
    localparam int SLOT_LOAD     = 1;
    localparam int SLOT_CHARGED  = 2;
    localparam int SLOT_DISCHRG  = 3;
    localparam int SLOT_IMPORT   = 4;
    localparam int SLOT_EXPORT   = 5;

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [DATE_W-1:0] DATE_TOP = 27'd99991231;
    localparam logic [DATE_W-1:0] DATE_A   = 27'd1234567;
    localparam logic [DATE_W-1:0] DATE_B   = 27'd7654321;

    typedef struct {
        logic [1:0]                kind;
        logic [TIME_W-1:0]         elapsed;
        logic                      online;
        logic signed [POWER_W-1:0] pv;
        logic signed [POWER_W-1:0] load;
        logic signed [POWER_W-1:0] bat;
        logic signed [POWER_W-1:0] grid;
        logic [MASK_W-1:0]         mask;
        logic signed [LEVEL_W-1:0] soc;
        logic [DATE_W-1:0]         date;
        logic [BUCKET_W-1:0]       bucket;
        logic [INDEX_W-1:0]        hidx;
    } meter_item_t;

    typedef struct {
        logic [SLOTS-1:0][SUM_W-1:0] sums;
        logic [COUNT_W-1:0]          count;
        logic [SOC_W-1:0]            value;
        logic                        cleared;
    } day_totals_t;

    // Tracks the unit's daily sums and charge ring, and queues the totals each item yields.
    class energy_ledger;
        logic [SLOTS-1:0][SUM_W-1:0] sums;
        logic [DATE_W-1:0]           stored_date;
        logic [SOC_W-1:0]            ring [HIST];
        logic [INDEX_W-1:0]          wp;
        logic [COUNT_W-1:0]          fill;
        logic [BUCKET_W-1:0]         last_bucket;
        logic                        bucket_seen;
        logic [TIME_W-1:0]           max_elapsed;
        day_totals_t                 expected_totals [$];
        int                          errors;
        string slot_names [SLOTS] = '{"pv_energy", "load_energy", "battery_charged",
                                      "battery_discharged", "grid_import", "grid_export"};

        function new();
            sums        = '0;
            stored_date = '0;
            wp          = '0;
            fill        = '0;
            last_bucket = '0;
            bucket_seen = 1'b0;
            max_elapsed = MAX_ELAPSED_RST;
            errors      = 0;
        endfunction

        function void set_limit(logic [TIME_W-1:0] v);
            max_elapsed = v;
        endfunction

        function int pending();
            return expected_totals.size();
        endfunction

        function logic [SUM_W-1:0] energy_of(logic signed [POWER_W-1:0] p,
                                             logic [TIME_W-1:0] t);
            logic [SUM_W-1:0] mag;
            logic [SUM_W-1:0] span;
            mag  = (p < 0) ? -p : p;
            span = SUM_W'(t);
            return mag * span;
        endfunction

        function void add_energy(int slot, logic [SUM_W-1:0] amount);
            logic [SUM_W:0] total;
            total = {1'b0, sums[slot]} + {1'b0, amount};
            sums[slot] = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
        endfunction

        // Sign picks the slot: negative power goes to neg_slot.
        function void add_split(logic signed [POWER_W-1:0] p, logic [TIME_W-1:0] t,
                                int neg_slot, int pos_slot);
            add_energy((p < 0) ? neg_slot : pos_slot, energy_of(p, t));
        endfunction

        // Updates the tracked state for one accepted item and queues its totals.
        function void note_item(meter_item_t it);
            day_totals_t        want;
            logic [SOC_W-1:0]   sample;
            logic [INDEX_W-1:0] pos;
            want.cleared = 1'b0;
            if (it.kind == dea_pkg::KIND_RESET_DAY) begin
                sums        = '0;
                stored_date = it.date;
                want.cleared = 1'b1;
            end else if (it.kind == dea_pkg::KIND_TICK) begin
                // A valid clock checks the date and may take a charge sample.
                if (it.date != '0) begin
                    if (stored_date != it.date) begin
                        sums        = '0;
                        stored_date = it.date;
                        want.cleared = 1'b1;
                    end
                    if (it.online && it.mask[MASK_SOC] &&
                        (!bucket_seen || it.bucket != last_bucket)) begin
                        if (it.soc < 0)
                            sample = '0;
                        else if (it.soc > SOC_MAX)
                            sample = SOC_W'(SOC_MAX);
                        else
                            sample = it.soc[SOC_W-1:0];
                        ring[wp] = sample;
                        wp = wp + 1'b1;
                        if (fill < HIST)
                            fill = fill + 1'b1;
                        last_bucket = it.bucket;
                        bucket_seen = 1'b1;
                    end
                end
                // Integration needs an online inverter and an elapsed time within the limit.
                if (it.online && it.elapsed != '0 && it.elapsed <= max_elapsed) begin
                    if (it.mask[MASK_PV] && it.pv > 0)
                        add_energy(SLOT_PV, energy_of(it.pv, it.elapsed));
                    if (it.mask[MASK_LOAD] && it.load > 0)
                        add_energy(SLOT_LOAD, energy_of(it.load, it.elapsed));
                    if (it.mask[MASK_BAT])
                        add_split(it.bat, it.elapsed, SLOT_CHARGED, SLOT_DISCHRG);
                    if (it.mask[MASK_GRID])
                        add_split(it.grid, it.elapsed, SLOT_IMPORT, SLOT_EXPORT);
                end
            end
            // History is read oldest first; the oldest entry sits at wp once the ring is full.
            want.value = '0;
            if (it.hidx < fill) begin
                pos = (fill < HIST) ? it.hidx : wp + it.hidx;
                want.value = ring[pos];
            end
            want.sums  = sums;
            want.count = fill;
            expected_totals.push_back(want);
        endfunction

        // Compares one result transfer with the oldest queued totals.
        function void check_result(logic [359:0] data, logic user);
            day_totals_t want;
            if (expected_totals.size() == 0) begin
                $error("result transfer with no item pending");
                errors++;
                return;
            end
            want = expected_totals.pop_front();
            for (int k = 0; k < SLOTS; k++) begin
                if (data[k*SUM_W +: SUM_W] !== want.sums[k]) begin
                    $error("%s: expected %0d, got %0d", slot_names[k], want.sums[k],
                           data[k*SUM_W +: SUM_W]);
                    errors++;
                end
            end
            if (data[SLOTS*SUM_W +: COUNT_W] !== want.count) begin
                $error("history_count: expected %0d, got %0d", want.count,
                       data[SLOTS*SUM_W +: COUNT_W]);
                errors++;
            end
            if (data[SLOTS*SUM_W+COUNT_W +: SOC_W] !== want.value) begin
                $error("history_value: expected %0d, got %0d", want.value,
                       data[SLOTS*SUM_W+COUNT_W +: SOC_W]);
                errors++;
            end
            if (user !== want.cleared) begin
                $error("day_cleared: expected %0d, got %0d", want.cleared, user);
                errors++;
            end
        endfunction
    endclass

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [207:0] s_tdata   = '0;
    logic [1:0]   s_tuser   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [359:0] m_tdata;
    logic         m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [31:0]  cfg_data  = '0;

    energy_ledger ledger = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    int cycle_count    = 0;

    logic [TIME_W-1:0]   limit_now  = MAX_ELAPSED_RST;
    logic [DATE_W-1:0]   cur_date   = DATE_A;
    logic [BUCKET_W-1:0] cur_bucket = '0;

    daily_energy_accumulator_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[daily_energy_accumulator_unit] ERROR");
            $finish;
        end
    end

    // Every result transfer is checked against the ledger.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            ledger.check_result(m_tdata, m_tuser);
    end

    // Result side: random stalls, plus a long hold-off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Called just after a falling edge; returns just after the falling edge that follows
    // the transfer, leaving tvalid high.
    task automatic push_item(meter_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {3'b0, it.hidx, it.bucket, it.date, it.soc, it.mask, it.grid, it.bat,
                     it.load, it.pv, it.online, it.elapsed};
        do @(posedge aclk); while (!s_tready);
        ledger.note_item(it);
        @(negedge aclk);
    endtask

    // Drops tvalid and waits until every result is in and the pipeline has drained.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (ledger.pending() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_limit(logic [TIME_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        ledger.set_limit(v);
        limit_now = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic meter_item_t base_item(logic [1:0] kind, logic [DATE_W-1:0] date,
                                              logic [BUCKET_W-1:0] bucket);
        meter_item_t it;
        it.kind    = kind;
        it.elapsed = 32'd1000;
        it.online  = 1'b1;
        it.pv      = 19'sd1500;
        it.load    = 19'sd800;
        it.bat     = -19'sd300;
        it.grid    = 19'sd250;
        it.mask    = '1;
        it.soc     = 16'sd5000;
        it.date    = date;
        it.bucket  = bucket;
        it.hidx    = '0;
        return it;
    endfunction

    function automatic logic signed [POWER_W-1:0] rand_power();
        int v;
        case ($urandom_range(19))
            0:       v = -200000;
            1:       v = 200000;
            2:       v = 0;
            default: v = int'($urandom_range(400000, 0)) - 200000;
        endcase
        return v[POWER_W-1:0];
    endfunction

    // Mostly ticks that keep the date and walk through buckets, with some noise.
    function automatic meter_item_t next_random_item();
        meter_item_t it;
        int r;
        r = $urandom_range(99);
        it.kind = (r < 78) ? dea_pkg::KIND_TICK : (r < 88) ? dea_pkg::KIND_RESET_DAY :
                  (r < 97) ? dea_pkg::KIND_READ : KIND_SPARE;
        if ($urandom_range(99) < 4)
            cur_date = DATE_W'($urandom_range(DATE_TOP, 1));
        it.date = ($urandom_range(99) < 5) ? '0 : cur_date;
        r = $urandom_range(99);
        if (r < 5)
            cur_bucket = BUCKET_W'({$urandom, $urandom});
        else if (r < 60)
            cur_bucket = cur_bucket + $urandom_range(3, 1);
        it.bucket = cur_bucket;
        case ($urandom_range(9))
            0:       it.elapsed = '0;
            1:       it.elapsed = limit_now;
            2:       it.elapsed = limit_now + 1'b1;
            3:       it.elapsed = $urandom;
            4:       it.elapsed = 32'd1;
            default: it.elapsed = $urandom_range(limit_now, 1);
        endcase
        it.online = ($urandom_range(99) < 88);
        it.mask   = ($urandom_range(99) < 65) ? 5'h1F : 5'($urandom_range(31));
        it.pv     = rand_power();
        it.load   = rand_power();
        it.bat    = rand_power();
        it.grid   = rand_power();
        it.soc    = ($urandom_range(99) < 80) ? 16'($urandom_range(SOC_MAX))
                                              : 16'($urandom_range(65535));
        if (ledger.fill != 0 && $urandom_range(99) < 70)
            it.hidx = INDEX_W'($urandom_range(ledger.fill - 1, 0));
        else
            it.hidx = INDEX_W'($urandom_range(255));
        return it;
    endfunction

    task automatic run_directed();
        meter_item_t it;
        // Read before anything is stored.
        it = base_item(dea_pkg::KIND_READ, '0, '0);
        push_item(it);
        // No valid clock: integrates, but no date check and no sample.
        it = base_item(dea_pkg::KIND_TICK, '0, '0);
        push_item(it);
        // New date clears; first bucket ever is sampled, negative charge clamps to zero.
        it = base_item(dea_pkg::KIND_TICK, DATE_A, '0);
        it.soc     = -16'sd5;
        it.elapsed = '0;
        push_item(it);
        // Same bucket, elapsed exactly at the limit, extreme powers.
        it = base_item(dea_pkg::KIND_TICK, DATE_A, '0);
        it.elapsed = MAX_ELAPSED_RST;
        it.pv      = 19'sd200000;
        it.load    = 19'sd200000;
        it.bat     = -19'sd200000;
        it.grid    = -19'sd200000;
        push_item(it);
        // Just past the limit: nothing added; high charge clamps.
        it = base_item(dea_pkg::KIND_TICK, DATE_A, 40'd1);
        it.elapsed = MAX_ELAPSED_RST + 1;
        it.soc     = 16'sd20000;
        push_item(it);
        // Charge not valid: dropped, bucket not recorded; discharging and export.
        it = base_item(dea_pkg::KIND_TICK, DATE_A, 40'd2);
        it.mask    = 5'b01111;
        it.elapsed = 32'd1;
        it.pv      = -19'sd200000;
        it.load    = -19'sd200000;
        it.bat     = 19'sd200000;
        it.grid    = 19'sd200000;
        push_item(it);
        // Inverter offline: no sample, no energy.
        it = base_item(dea_pkg::KIND_TICK, DATE_A, 40'd2);
        it.online = 1'b0;
        push_item(it);
        // Only the charge is valid: sample taken, no energy.
        it = base_item(dea_pkg::KIND_TICK, DATE_A, 40'd2);
        it.mask = 5'b10000;
        it.soc  = 16'sd10000;
        push_item(it);
        // Unused kind reads; history reads inside and past the count.
        it = base_item(KIND_SPARE, DATE_B, 40'd9);
        it.hidx = 8'd1;
        push_item(it);
        it = base_item(dea_pkg::KIND_READ, '0, '0);
        it.hidx = 8'd3;
        push_item(it);
        it.hidx = 8'd255;
        push_item(it);
        it.hidx = 8'd2;
        push_item(it);
        // Day reset to a new date, then a tick on that date does not clear again.
        it = base_item(dea_pkg::KIND_RESET_DAY, DATE_B, '0);
        push_item(it);
        it = base_item(dea_pkg::KIND_TICK, DATE_B, 40'd3);
        push_item(it);
        // Day reset with no valid clock, then a tick beyond the limit.
        it = base_item(dea_pkg::KIND_RESET_DAY, '0, '0);
        push_item(it);
        it = base_item(dea_pkg::KIND_TICK, '0, '0);
        it.elapsed = '1;
        push_item(it);
        // Largest date and bucket, largest and smallest charge, zero power, empty mask.
        it = base_item(dea_pkg::KIND_TICK, DATE_TOP, '1);
        it.soc     = 16'sh7FFF;
        it.elapsed = 32'd1;
        push_item(it);
        it = base_item(dea_pkg::KIND_TICK, DATE_TOP, '0);
        it.soc  = 16'sh8000;
        it.pv   = '0;
        it.load = '0;
        it.bat  = '0;
        it.grid = '0;
        it.hidx = 8'd4;
        push_item(it);
        it = base_item(dea_pkg::KIND_TICK, DATE_TOP, '0);
        it.mask    = '0;
        it.elapsed = 32'd5;
        push_item(it);
    endtask

    // Long intervals at high power on one date drive every sum into saturation.
    task automatic run_saturation(int per_sign);
        meter_item_t it;
        for (int n = 0; n < 2 * per_sign; n++) begin
            it = base_item(dea_pkg::KIND_TICK, cur_date, cur_bucket);
            cur_bucket  = cur_bucket + 1'b1;
            it.bucket   = cur_bucket;
            it.elapsed  = $urandom_range(32'hFFFF_FFFF, 32'hF000_0000);
            it.pv       = 19'($urandom_range(200000, 180000));
            it.load     = 19'($urandom_range(200000, 180000));
            it.bat      = 19'($urandom_range(200000, 180000));
            it.grid     = 19'($urandom_range(200000, 180000));
            if (n < per_sign) begin
                it.bat  = -it.bat;
                it.grid = -it.grid;
            end
            it.soc  = 16'($urandom_range(SOC_MAX));
            it.hidx = INDEX_W'($urandom_range(255));
            push_item(it);
        end
    endtask

    task automatic run_random(int items, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (items) push_item(next_random_item());
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        run_directed();
        drain();

        // Widest limit: saturation with no idling, then the receiver holds off.
        write_limit(32'hFFFF_FFFF);
        cur_date = DATE_W'($urandom_range(DATE_TOP, 1));
        run_saturation(110);
        hold_request = 1'b1;
        run_random(24, 0, 0);
        drain();

        write_limit(32'd1);
        run_random(150, 45, 0);
        drain();

        write_limit($urandom_range(32'hFFFF_FFFF, 1));
        run_random(220, 0, 45);
        drain();

        write_limit(MAX_ELAPSED_RST);
        run_random(220, 9, 9);
        drain();

        repeat (10) @(posedge aclk);
        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("[daily_energy_accumulator_unit] OK");
        else
            $display("[daily_energy_accumulator_unit] ERROR");
        $finish;
    end

endmodule
